/* sv/resolver_multiturn_tracker_unit_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the resolver multi-turn tracker.
// Both macros sample on clk_i and are off while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef RESOLVER_MULTITURN_TRACKER_UNIT_ASSERT_SVH
`define RESOLVER_MULTITURN_TRACKER_UNIT_ASSERT_SVH

// Same-cycle implication.
`define RMT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define RMT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/rmt_pkg.sv */
// ----------------------------------------------------------------------------
// rmt_pkg
// Types, codes and constants shared by the resolver multi-turn tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package rmt_pkg;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned DP_W       = 64;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_RESOLVER_SELECT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REVERSE_ANGLE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REDUCTION       = 2'd2;

  localparam logic [15:0] REDUCTION_RESET = 16'd256;

  // Result status codes.
  localparam logic [2:0] ST_TICK     = 3'd0;
  localparam logic [2:0] ST_USED     = 3'd1;
  localparam logic [2:0] ST_INIT     = 3'd2;
  localparam logic [2:0] ST_OTHER_ID = 3'd3;
  localparam logic [2:0] ST_FLAGGED  = 3'd4;

  // Half a turn in counts; 32767 counts stand for pi.
  localparam logic signed [17:0] HALF_TURN = 18'sd32767;

  // Serial divider: quotient bits per pass. The dividend magnitude sits
  // left-justified in the 64-bit shift register.
  localparam int unsigned DIV_POS_BITS = 40;
  localparam int unsigned DIV_VEL_BITS = 62;
  // Position dividend is |counts| * 256, left-justified for DIV_POS_BITS.
  localparam int unsigned DIV_POS_SHIFT = 8 + DP_W - DIV_POS_BITS;
  localparam int unsigned DIV_VEL_SHIFT = DP_W - DIV_VEL_BITS;

  // Microseconds per second, multiplied in one bit per cycle.
  localparam int unsigned MUL_BITS  = 20;
  localparam logic [MUL_BITS-1:0] VEL_SCALE = 20'd1000000;

  localparam logic [47:0] POS_MAX48 = 48'h7FFF_FFFF_FFFF;
  localparam logic [47:0] POS_MIN48 = 48'h8000_0000_0000;

  typedef struct packed {
    logic        cmd;
    logic [7:0]  frame_resolver_id;
    logic [7:0]  frame_flags;
    logic [7:0]  frame_angle_high;
    logic [7:0]  frame_angle_low;
    logic [19:0] period_us;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         status;
    logic signed [47:0] position;
    logic signed [47:0] velocity;
    logic signed [15:0] turns;
    logic [7:0]         flags_seen;
  } out_item_t;

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_e;

  typedef struct packed {
    alu_op_e         op;
    logic [DP_W-1:0] a;
    logic [DP_W-1:0] b;
  } alu_req_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FRAME,
    S_CNT_HI,
    S_CNT_LO,
    S_ABS_CNT,
    S_DIV,
    S_POS,
    S_DIFF,
    S_ABS_DIFF,
    S_MUL,
    S_VEL
  } state_e;

endpackage

`default_nettype wire

/* sv/rmt_alu.sv */
// ----------------------------------------------------------------------------
// rmt_alu
// Shared 64-bit adder/subtractor used for every arithmetic step of a tick.
// ----------------------------------------------------------------------------
`default_nettype none

module rmt_alu (
  input  rmt_pkg::alu_req_t             req_i,
  output logic [rmt_pkg::DP_W-1:0]      res_o
);

  always_comb begin
    unique case (req_i.op)
      rmt_pkg::ALU_ADD: res_o = req_i.a + req_i.b;
      rmt_pkg::ALU_SUB: res_o = req_i.a - req_i.b;
      default:          res_o = req_i.a + req_i.b;
    endcase
  end

endmodule

`default_nettype wire

/* sv/resolver_multiturn_tracker_unit.sv */
// ----------------------------------------------------------------------------
// resolver_multiturn_tracker_unit
// Unwraps resolver angle frames into a turn count and reports multi-turn
// position and velocity on control ticks.
//
//   channel | dir | handshake                   | payload
//   --------+-----+-----------------------------+----------------------
//   in      | in  | in_valid_i / in_stall_o     | rmt_pkg::in_item_t
//   out     | out | out_valid_o / out_stall_i   | rmt_pkg::out_item_t
//   cfg     | in  | cfg_we_i (index, data)      | cfg_index_i, cfg_data_i
//
// A frame item is handled in S_FRAME, which returns to S_IDLE for the next item.
// A tick item runs three setup steps, a 40-step position division, three
// steps, a 20-step multiply by 1e6 and a 62-step velocity division, all on
// the one shared adder (rmt_alu), plus the final step.
// A finished result waits in its state while the output register is full
// and stalled; a new item is taken as soon as that result is registered.
// Reset clears the tracking state and sets the configuration registers to their defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module resolver_multiturn_tracker_unit (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  rmt_pkg::in_item_t                    in_item_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output rmt_pkg::out_item_t                   out_item_o,
  input  logic                                 cfg_we_i,
  input  logic [rmt_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [rmt_pkg::CFG_DATA_W-1:0]       cfg_data_i
);

  // Configuration registers.
  logic [7:0]  sel_q;
  logic        rev_q;
  logic [15:0] red_q;

  // Tracking state.
  logic signed [16:0] last_angle_q, last_angle_d;
  logic signed [15:0] turn_q, turn_d;
  logic               valid_q, valid_d;
  logic signed [47:0] last_pos_q, last_pos_d;
  logic signed [47:0] last_vel_q, last_vel_d;

  // Sequencer and datapath.
  rmt_pkg::state_e     state_q, state_d;
  rmt_pkg::in_item_t   in_q, in_d;
  logic [63:0]         acc_q, acc_d;
  logic [63:0]         dq_q, dq_d;
  logic [19:0]         rem_q, rem_d;
  logic [19:0]         div_q, div_d;
  logic [5:0]          cnt_q, cnt_d;
  logic                pass_q, pass_d;
  logic                neg_q, neg_d;
  logic signed [47:0]  pos_q, pos_d;

  logic                out_valid_q, out_valid_d;
  rmt_pkg::out_item_t  out_q, out_d;

  rmt_pkg::alu_req_t   alu_req;
  logic [63:0]         alu_res;

  // Frame decode.
  logic [15:0]         raw_angle;
  logic signed [16:0]  angle;
  logic signed [17:0]  delta;
  logic                turn_up, turn_down;
  logic signed [15:0]  turn_next;
  logic [15:0]         red_eff;
  logic [19:0]         per_eff;
  logic [20:0]         div_shift;
  logic                div_ge;
  logic                out_free;
  logic                vel_big;
  logic signed [47:0]  vel_val;

  rmt_alu u_alu (
    .req_i (alu_req),
    .res_o (alu_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q <= 8'h00;
      rev_q <= 1'b0;
      red_q <= rmt_pkg::REDUCTION_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        rmt_pkg::CFG_RESOLVER_SELECT: sel_q <= cfg_data_i[7:0];
        rmt_pkg::CFG_REVERSE_ANGLE:   rev_q <= cfg_data_i[0];
        rmt_pkg::CFG_REDUCTION:       red_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= rmt_pkg::S_IDLE;
      last_angle_q <= '0;
      turn_q       <= '0;
      valid_q      <= 1'b0;
      last_pos_q   <= '0;
      last_vel_q   <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      last_angle_q <= last_angle_d;
      turn_q       <= turn_d;
      valid_q      <= valid_d;
      last_pos_q   <= last_pos_d;
      last_vel_q   <= last_vel_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    in_q   <= in_d;
    acc_q  <= acc_d;
    dq_q   <= dq_d;
    rem_q  <= rem_d;
    div_q  <= div_d;
    cnt_q  <= cnt_d;
    pass_q <= pass_d;
    neg_q  <= neg_d;
    pos_q  <= pos_d;
    out_q  <= out_d;
  end

  // Angle unpack and wrap detection.
  assign raw_angle = {in_q.frame_angle_high[5:0], in_q.frame_angle_low, 2'b00};
  assign angle     = rev_q ? (17'sd0 - {raw_angle[15], raw_angle})
                           : {raw_angle[15], raw_angle};
  assign delta     = {angle[16], angle} - {last_angle_q[16], last_angle_q};
  // An exact half turn follows the sign of the last velocity.
  assign turn_up   = (delta < -rmt_pkg::HALF_TURN) ||
                     (((delta == rmt_pkg::HALF_TURN) ||
                       (delta == -rmt_pkg::HALF_TURN)) && !last_vel_q[47]);
  assign turn_down = (delta > rmt_pkg::HALF_TURN) ||
                     (((delta == rmt_pkg::HALF_TURN) ||
                       (delta == -rmt_pkg::HALF_TURN)) && last_vel_q[47]);

  always_comb begin
    turn_next = turn_q;
    if (turn_up && (turn_q != 16'sh7FFF)) begin
      turn_next = turn_q + 16'sd1;
    end else if (turn_down && (turn_q != 16'sh8000)) begin
      turn_next = turn_q - 16'sd1;
    end
  end

  assign red_eff   = (red_q == 16'h0000) ? 16'h0001 : red_q;
  assign per_eff   = (in_q.period_us == 20'h00000) ? 20'h00001 : in_q.period_us;
  assign div_shift = {rem_q, dq_q[63]};
  assign div_ge    = !alu_res[63];
  assign out_free  = !out_valid_q || !out_stall_i;
  assign vel_big   = |dq_q[61:47];

  always_comb begin
    if (!neg_q) begin
      vel_val = vel_big ? rmt_pkg::POS_MAX48 : dq_q[47:0];
    end else begin
      vel_val = vel_big ? rmt_pkg::POS_MIN48 : alu_res[47:0];
    end
  end

  always_comb begin
    state_d      = state_q;
    in_d         = in_q;
    acc_d        = acc_q;
    dq_d         = dq_q;
    rem_d        = rem_q;
    div_d        = div_q;
    cnt_d        = cnt_q;
    pass_d       = pass_q;
    neg_d        = neg_q;
    pos_d        = pos_q;
    last_angle_d = last_angle_q;
    turn_d       = turn_q;
    valid_d      = valid_q;
    last_pos_d   = last_pos_q;
    last_vel_d   = last_vel_q;
    out_d        = out_q;
    out_valid_d  = out_valid_q && out_stall_i;
    in_stall_o   = 1'b1;
    alu_req.op   = rmt_pkg::ALU_ADD;
    alu_req.a    = acc_q;
    alu_req.b    = 64'h0;

    unique case (state_q)
      rmt_pkg::S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          in_d    = in_item_i;
          state_d = in_item_i.cmd ? rmt_pkg::S_CNT_HI : rmt_pkg::S_FRAME;
        end
      end

      rmt_pkg::S_FRAME: begin
        if (out_free) begin
          out_valid_d         = 1'b1;
          out_d.position      = last_pos_q;
          out_d.velocity      = last_vel_q;
          out_d.flags_seen    = 8'h00;
          out_d.turns         = turn_q;
          state_d             = rmt_pkg::S_IDLE;
          if (in_q.frame_resolver_id != sel_q) begin
            out_d.status = rmt_pkg::ST_OTHER_ID;
          end else if (in_q.frame_flags != 8'h00) begin
            out_d.status     = rmt_pkg::ST_FLAGGED;
            out_d.flags_seen = in_q.frame_flags;
          end else if (!valid_q) begin
            out_d.status = rmt_pkg::ST_INIT;
            last_angle_d = angle;
            valid_d      = 1'b1;
          end else begin
            out_d.status = rmt_pkg::ST_USED;
            last_angle_d = angle;
            turn_d       = turn_next;
            out_d.turns  = turn_next;
          end
        end
      end

      // counts = angle + 65534 * turns = angle + (turns << 16) - (turns << 1)
      rmt_pkg::S_CNT_HI: begin
        alu_req.a = {{32{turn_q[15]}}, turn_q, 16'h0000};
        alu_req.b = {{47{last_angle_q[16]}}, last_angle_q};
        acc_d     = alu_res;
        state_d   = rmt_pkg::S_CNT_LO;
      end

      rmt_pkg::S_CNT_LO: begin
        alu_req.op = rmt_pkg::ALU_SUB;
        alu_req.b  = {{47{turn_q[15]}}, turn_q, 1'b0};
        acc_d      = alu_res;
        state_d    = rmt_pkg::S_ABS_CNT;
      end

      rmt_pkg::S_ABS_CNT: begin
        neg_d = acc_q[63];
        if (acc_q[63]) begin
          alu_req.op = rmt_pkg::ALU_SUB;
          alu_req.a  = 64'h0;
          alu_req.b  = acc_q;
        end
        dq_d    = alu_res << rmt_pkg::DIV_POS_SHIFT;
        rem_d   = 20'h00000;
        div_d   = {4'h0, red_eff};
        cnt_d   = 6'(rmt_pkg::DIV_POS_BITS);
        pass_d  = 1'b0;
        state_d = rmt_pkg::S_DIV;
      end

      // Restoring division, one quotient bit per cycle.
      rmt_pkg::S_DIV: begin
        alu_req.op = rmt_pkg::ALU_SUB;
        alu_req.a  = {43'h0, div_shift};
        alu_req.b  = {44'h0, div_q};
        rem_d      = div_ge ? alu_res[19:0] : div_shift[19:0];
        dq_d       = {dq_q[62:0], div_ge};
        cnt_d      = cnt_q - 6'd1;
        if (cnt_q == 6'd1) begin
          state_d = pass_q ? rmt_pkg::S_VEL : rmt_pkg::S_POS;
        end
      end

      rmt_pkg::S_POS: begin
        if (neg_q) begin
          alu_req.op = rmt_pkg::ALU_SUB;
          alu_req.a  = 64'h0;
          alu_req.b  = {24'h0, dq_q[39:0]};
        end else begin
          alu_req.a  = {24'h0, dq_q[39:0]};
        end
        pos_d   = alu_res[47:0];
        state_d = rmt_pkg::S_DIFF;
      end

      rmt_pkg::S_DIFF: begin
        alu_req.op = rmt_pkg::ALU_SUB;
        alu_req.a  = {{16{pos_q[47]}}, pos_q};
        alu_req.b  = {{16{last_pos_q[47]}}, last_pos_q};
        acc_d      = alu_res;
        state_d    = rmt_pkg::S_ABS_DIFF;
      end

      rmt_pkg::S_ABS_DIFF: begin
        neg_d = acc_q[63];
        if (acc_q[63]) begin
          alu_req.op = rmt_pkg::ALU_SUB;
          alu_req.a  = 64'h0;
          alu_req.b  = acc_q;
        end
        acc_d   = alu_res;
        dq_d    = 64'h0;
        cnt_d   = 6'(rmt_pkg::MUL_BITS - 1);
        state_d = rmt_pkg::S_MUL;
      end

      // Shift-add multiply by 1e6, most significant constant bit first.
      rmt_pkg::S_MUL: begin
        alu_req.a = {dq_q[62:0], 1'b0};
        alu_req.b = rmt_pkg::VEL_SCALE[cnt_q[4:0]] ? acc_q : 64'h0;
        dq_d      = alu_res;
        cnt_d     = cnt_q - 6'd1;
        if (cnt_q == 6'd0) begin
          dq_d    = alu_res << rmt_pkg::DIV_VEL_SHIFT;
          rem_d   = 20'h00000;
          div_d   = per_eff;
          cnt_d   = 6'(rmt_pkg::DIV_VEL_BITS);
          pass_d  = 1'b1;
          state_d = rmt_pkg::S_DIV;
        end
      end

      rmt_pkg::S_VEL: begin
        alu_req.op = rmt_pkg::ALU_SUB;
        alu_req.a  = 64'h0;
        alu_req.b  = {2'b00, dq_q[61:0]};
        if (out_free) begin
          out_valid_d      = 1'b1;
          out_d.status     = rmt_pkg::ST_TICK;
          out_d.position   = pos_q;
          out_d.velocity   = vel_val;
          out_d.turns      = turn_q;
          out_d.flags_seen = 8'h00;
          last_pos_d       = pos_q;
          last_vel_d       = vel_val;
          state_d          = rmt_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = rmt_pkg::S_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

`default_nettype wire

/* sv/rmt_checker.sv */
// ----------------------------------------------------------------------------
// rmt_checker
// Port-level checks on the resolver multi-turn tracker, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

`include "resolver_multiturn_tracker_unit_assert.svh"

module rmt_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  input  logic                           in_stall_o,
  input  logic                           out_valid_o,
  input  logic                           out_stall_i,
  input  rmt_pkg::out_item_t             out_item_o
);

  // A stalled result stays and does not change.
  `RMT_ASSERT_NXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_item_o), "out item dropped or changed under stall")

  // The block is busy right after it takes an item.
  `RMT_ASSERT_NXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o, "input not stalled after accepting an item")

  // A new result only appears at the end of work on an item.
  `RMT_ASSERT_IMP(a_result_from_work, $rose(out_valid_o), $past(in_stall_o), "result appeared without an item in work")

  // Only a flagged frame reports a flag byte.
  `RMT_ASSERT_IMP(a_flags_only_flagged, out_valid_o && (out_item_o.flags_seen != 8'h00), out_item_o.status == rmt_pkg::ST_FLAGGED, "flag byte reported on a non-flagged item")

endmodule

bind resolver_multiturn_tracker_unit rmt_checker u_rmt_checker (.*);

`default_nettype wire
